// File: rtl/slt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the shell line tokenizer.
// No dependencies; imported by the channel interfaces, the top level and the checker.
package slt_pkg;

    localparam int MAX_CAPACITY = 4096;
    localparam int MIN_CAPACITY = 5;
    localparam int CAP_W        = 13;
    localparam int COUNT_W      = 12;
    localparam int BYTE_W       = 8;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;

    localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(64);
    localparam logic [CAP_W-1:0]   CAP_MIN   = CAP_W'(MIN_CAPACITY);
    localparam logic [CAP_W-1:0]   CAP_MAX   = CAP_W'(MAX_CAPACITY);
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

    // Scanner state, one-hot
    typedef enum logic [5:0] {
        MODE_START  = 6'b000001,
        MODE_GAP    = 6'b000010,
        MODE_PLAIN  = 6'b000100,
        MODE_QUOTED = 6'b001000,
        MODE_QMARK  = 6'b010000,
        MODE_SKIP   = 6'b100000
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR  = 2'd0,
        KIND_END   = 2'd1,
        KIND_LINE  = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_BADQUOTE = 2'd3
    } status_t;

    function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] value);
        logic [CAP_W-1:0] c;
        c = value;
        if (c < CAP_MIN)
        begin
            c = CAP_MIN;
        end
        if (c > CAP_MAX)
        begin
            c = CAP_MAX;
        end
        return c;
    endfunction

endpackage

// File: rtl/slt_line_if.sv
`timescale 1ns / 1ps
// Input channel: one command line byte per transfer.
// Depends on slt_pkg.
interface slt_line_if;
    import slt_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] line_byte;

    modport source (output valid, output line_byte, input ready);
    modport sink   (input valid, input line_byte, output ready);
endinterface

// File: rtl/slt_item_if.sv
`timescale 1ns / 1ps
// Output channel: token bytes, token ends and line status items.
// Depends on slt_pkg.
interface slt_item_if;
    import slt_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   item_kind;
    logic [BYTE_W-1:0]   token_byte;
    logic [STATUS_W-1:0] line_status;
    logic [COUNT_W-1:0]  token_total;

    modport source (output valid, output item_kind, output token_byte,
                    output line_status, output token_total, input ready);
    modport sink   (input valid, input item_kind, input token_byte,
                    input line_status, input token_total, output ready);
endinterface

// File: rtl/shell_line_tokenizer.sv
`timescale 1ns / 1ps
// Shell line tokenizer top level: input register, scanner logic, output register.
// Depends on slt_pkg, slt_line_if, slt_item_if.
//
//  Channel   Dir  Handshake          Payload
//  line_ch   in   valid/ready        line_byte[7:0]
//  item_ch   out  valid/ready        item_kind[1:0] token_byte[7:0] line_status[1:0]
//                                    token_total[11:0]
//  cfg       in   cfg_wr_en          cfg_wr_data[12:0] (buffer capacity)
//
// One byte per cycle unless the output stalls; results are registered at the output.
// Scanner state (mode, bytes used, token count) feeds back through combinational logic.
// rst_n clears the line state, capacity returns to 64; no clearing pass.
// A stalled output holds its item while the input register takes one more byte;
// the input stalls only when both registers are full.
module shell_line_tokenizer (
    input  logic                      clk,
    input  logic                      rst_n,
    slt_line_if.sink                  line_ch,
    slt_item_if.source                item_ch,
    input  logic                      cfg_wr_en,
    input  logic [slt_pkg::CAP_W-1:0] cfg_wr_data
);
    import slt_pkg::*;

    logic [CAP_W-1:0]    cap_reg;
    logic                byte_valid_reg;
    logic [BYTE_W-1:0]   byte_reg;
    mode_t               mode_reg, mode_next;
    logic [CAP_W-1:0]    used_reg, used_next;
    logic [COUNT_W-1:0]  tokens_reg, tokens_next;
    status_t             err_reg, err_next;

    logic                out_valid_reg;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [BYTE_W-1:0]   tbyte_reg, tbyte_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [COUNT_W-1:0]  total_reg, total_next;
    logic                res_valid;

    logic                scan_fire;
    logic                has_room;
    logic                start_room;
    logic [COUNT_W-1:0]  tokens_inc;

    assign scan_fire     = byte_valid_reg && (!out_valid_reg || item_ch.ready);
    assign line_ch.ready = !byte_valid_reg || scan_fire;

    assign has_room   = ({1'b0, used_reg} + (CAP_W+1)'(1)) < {1'b0, cap_reg};
    assign start_room = used_reg < cap_reg;
    assign tokens_inc = (tokens_reg == COUNT_SAT) ? tokens_reg : tokens_reg + COUNT_W'(1);

    always_comb
    begin
        mode_next   = mode_reg;
        used_next   = used_reg;
        tokens_next = tokens_reg;
        err_next    = err_reg;
        res_valid   = 1'b0;
        kind_next   = KIND_CHAR;
        tbyte_next  = CHAR_NUL;
        status_next = ST_OK;
        total_next  = '0;

        if (byte_reg < CHAR_SPACE)
        begin
            // line end: report and reset line state
            res_valid   = 1'b1;
            kind_next   = KIND_LINE;
            total_next  = tokens_reg;
            mode_next   = MODE_START;
            used_next   = '0;
            tokens_next = '0;
            err_next    = ST_OK;
            case (mode_reg)
                MODE_START:  status_next = ST_EMPTY;
                MODE_GAP:    status_next = ST_OK;
                MODE_PLAIN,
                MODE_QMARK:
                begin
                    status_next = ST_OK;
                    total_next  = tokens_inc;
                end
                MODE_QUOTED: status_next = ST_BADQUOTE;
                default:     status_next = err_reg;
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_START,
                MODE_GAP:
                begin
                    if (byte_reg != CHAR_SPACE)
                    begin
                        if (!start_room)
                        begin
                            err_next  = ST_OVERFLOW;
                            mode_next = MODE_SKIP;
                        end
                        else if (byte_reg == CHAR_QUOTE)
                        begin
                            mode_next = MODE_QUOTED;
                        end
                        else if (!has_room)
                        begin
                            err_next  = ST_OVERFLOW;
                            mode_next = MODE_SKIP;
                        end
                        else
                        begin
                            res_valid  = 1'b1;
                            tbyte_next = byte_reg;
                            used_next  = used_reg + CAP_W'(1);
                            mode_next  = MODE_PLAIN;
                        end
                    end
                end
                MODE_PLAIN:
                begin
                    if (byte_reg == CHAR_SPACE)
                    begin
                        res_valid   = 1'b1;
                        kind_next   = KIND_END;
                        used_next   = used_reg + CAP_W'(1);
                        tokens_next = tokens_inc;
                        mode_next   = MODE_GAP;
                    end
                    else if (!has_room)
                    begin
                        err_next  = ST_OVERFLOW;
                        mode_next = MODE_SKIP;
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        tbyte_next = byte_reg;
                        used_next  = used_reg + CAP_W'(1);
                    end
                end
                MODE_QUOTED:
                begin
                    if (byte_reg == CHAR_QUOTE)
                    begin
                        mode_next = MODE_QMARK;
                    end
                    else if (!has_room)
                    begin
                        err_next  = ST_BADQUOTE;
                        mode_next = MODE_SKIP;
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        tbyte_next = byte_reg;
                        used_next  = used_reg + CAP_W'(1);
                    end
                end
                MODE_QMARK:
                begin
                    if (byte_reg == CHAR_QUOTE)
                    begin
                        // doubled quote is a literal quote
                        if (!has_room)
                        begin
                            err_next  = ST_BADQUOTE;
                            mode_next = MODE_SKIP;
                        end
                        else
                        begin
                            res_valid  = 1'b1;
                            tbyte_next = byte_reg;
                            used_next  = used_reg + CAP_W'(1);
                            mode_next  = MODE_QUOTED;
                        end
                    end
                    else if (byte_reg == CHAR_SPACE)
                    begin
                        res_valid   = 1'b1;
                        kind_next   = KIND_END;
                        used_next   = used_reg + CAP_W'(1);
                        tokens_next = tokens_inc;
                        mode_next   = MODE_GAP;
                    end
                    else
                    begin
                        err_next  = ST_BADQUOTE;
                        mode_next = MODE_SKIP;
                    end
                end
                default:
                begin
                    mode_next = MODE_SKIP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CAP_RESET;
            byte_valid_reg <= 1'b0;
            mode_reg       <= MODE_START;
            used_reg       <= '0;
            tokens_reg     <= '0;
            err_reg        <= ST_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= clamp_cap(cfg_wr_data);
            end
            if (line_ch.ready)
            begin
                byte_valid_reg <= line_ch.valid;
            end
            if (scan_fire)
            begin
                mode_reg   <= mode_next;
                used_reg   <= used_next;
                tokens_reg <= tokens_next;
                err_reg    <= err_next;
            end
            if (scan_fire && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (item_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (line_ch.ready && line_ch.valid)
        begin
            byte_reg <= line_ch.line_byte;
        end
        if (scan_fire && res_valid)
        begin
            kind_reg   <= kind_next;
            tbyte_reg  <= tbyte_next;
            status_reg <= status_next;
            total_reg  <= total_next;
        end
    end

    assign item_ch.valid       = out_valid_reg;
    assign item_ch.item_kind   = kind_reg;
    assign item_ch.token_byte  = tbyte_reg;
    assign item_ch.line_status = status_reg;
    assign item_ch.token_total = total_reg;

endmodule

// File: rtl/slt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the shell line tokenizer, bound to the top level.
// Depends on slt_pkg and shell_line_tokenizer.
module slt_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [slt_pkg::KIND_W-1:0]   item_kind,
    input  logic [slt_pkg::BYTE_W-1:0]   token_byte,
    input  logic [slt_pkg::STATUS_W-1:0] line_status,
    input  logic [slt_pkg::COUNT_W-1:0]  token_total
);
    import slt_pkg::*;

    // stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_kind)
            && $stable(token_byte) && $stable(line_status) && $stable(token_total))
        else $error("stalled item changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> item_kind == KIND_CHAR || item_kind == KIND_END
            || item_kind == KIND_LINE)
        else $error("undefined item kind");

    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind != KIND_LINE |-> line_status == ST_OK && token_total == '0)
        else $error("status fields set on token item");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind != KIND_CHAR |-> token_byte == CHAR_NUL
            && !(item_kind == KIND_LINE && line_status == ST_EMPTY && token_total != '0))
        else $error("bad byte or count on non-character item");

endmodule

bind shell_line_tokenizer slt_checker u_slt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (item_ch.valid),
    .out_ready   (item_ch.ready),
    .item_kind   (item_ch.item_kind),
    .token_byte  (item_ch.token_byte),
    .line_status (item_ch.line_status),
    .token_total (item_ch.token_total)
);
